### design/fnw_pkg.sv
// ----------------------------------------------------------------------------
// fnw_pkg
// Shared constants and controller/datapath handshake types for the
// flip-n-write cost model.
// ----------------------------------------------------------------------------
package fnw_pkg;

   localparam int DATA_W      = 64;
   localparam int WIDTH_W     = 7;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 7;
   localparam int TOTAL_W     = 64;
   localparam int NUM_ENTRIES = 1024;
   localparam int ENTRY_AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

   localparam int REQ_W  = 80;    // entry_index + write_data, byte padded
   localparam int RSP_W  = 336;   // all result fields but the flip flag

   typedef struct packed {
      logic accept;
      logic count;
      logic commit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic clear_last;
   } status_type;

endpackage

### design/fnw_ctrl.sv
// ----------------------------------------------------------------------------
// fnw_ctrl
// Sequencer: clears the table after reset, then steps each item through
// read, count and commit.
// ----------------------------------------------------------------------------
module fnw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  fnw_pkg::status_type  status,
   output fnw_pkg::cmd_type     cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_COUNT  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the output register can take the result
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/fnw_datapath.sv
// ----------------------------------------------------------------------------
// fnw_datapath
// Word table, ones counting, flip decision, saturating totals and the
// result register.
// ----------------------------------------------------------------------------
module fnw_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  fnw_pkg::cmd_type                   cmd,
   output fnw_pkg::status_type                status,
   input  logic                               csr_valid,
   input  logic [fnw_pkg::WIDTH_W-1:0]        csr_data,
   input  logic [fnw_pkg::IDX_W-1:0]          entry_index,
   input  logic [fnw_pkg::DATA_W-1:0]         write_data,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic                               flip_chosen,
   output logic [fnw_pkg::DATA_W-1:0]         stored_word,
   output logic [fnw_pkg::CNT_W-1:0]          injected_now,
   output logic [fnw_pkg::CNT_W-1:0]          removed_now,
   output logic [fnw_pkg::TOTAL_W-1:0]        total_shifts,
   output logic [fnw_pkg::TOTAL_W-1:0]        total_detects,
   output logic [fnw_pkg::TOTAL_W-1:0]        total_injections,
   output logic [fnw_pkg::TOTAL_W-1:0]        total_removals
);

   localparam int NBYTES = fnw_pkg::DATA_W / 8;

   // byte-wise count, then sum of the byte counts
   function automatic logic [fnw_pkg::CNT_W-1:0] ones_of(input logic [fnw_pkg::DATA_W-1:0] v);
      logic [3:0]                byte_cnt [NBYTES];
      logic [fnw_pkg::CNT_W-1:0] sum;
      sum = '0;
      for (int b = 0; b < NBYTES; b++) begin
         byte_cnt[b] = '0;
         for (int i = 0; i < 8; i++) begin
            byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+i]);
         end
      end
      for (int b = 0; b < NBYTES; b++) begin
         sum = sum + fnw_pkg::CNT_W'(byte_cnt[b]);
      end
      return sum;
   endfunction

   function automatic logic [fnw_pkg::TOTAL_W-1:0] sat_add(
      input logic [fnw_pkg::TOTAL_W-1:0] a,
      input logic [7:0]                  b);
      logic [fnw_pkg::TOTAL_W:0] s;
      s = {1'b0, a} + (fnw_pkg::TOTAL_W+1)'(b);
      return s[fnw_pkg::TOTAL_W] ? '1 : s[fnw_pkg::TOTAL_W-1:0];
   endfunction

   // table: flip bit on top of the data word
   logic [fnw_pkg::DATA_W:0] mem [fnw_pkg::NUM_ENTRIES];

   logic [fnw_pkg::WIDTH_W-1:0]  width_ff;
   logic [fnw_pkg::WIDTH_W-1:0]  w_eff;
   logic [fnw_pkg::DATA_W-1:0]   mask_in;
   logic [fnw_pkg::ENTRY_AW-1:0] clear_addr_ff;

   logic [fnw_pkg::ENTRY_AW-1:0] addr_ff;
   logic                         in_range_ff;
   logic [fnw_pkg::WIDTH_W-1:0]  w_ff;
   logic [fnw_pkg::DATA_W-1:0]   mask_ff;
   logic [fnw_pkg::DATA_W-1:0]   data_ff;
   logic [fnw_pkg::DATA_W:0]     rd_ff;
   logic [fnw_pkg::CNT_W-1:0]    resident_ff;
   logic [fnw_pkg::CNT_W-1:0]    ones_ff;

   logic [fnw_pkg::TOTAL_W-1:0]  shift_total_ff;
   logic [fnw_pkg::TOTAL_W-1:0]  detect_total_ff;
   logic [fnw_pkg::TOTAL_W-1:0]  inject_total_ff;
   logic [fnw_pkg::TOTAL_W-1:0]  remove_total_ff;

   logic                         out_valid_ff;
   logic                         out_flip_ff;
   logic [fnw_pkg::DATA_W-1:0]   out_word_ff;
   logic [fnw_pkg::CNT_W-1:0]    out_inj_ff;
   logic [fnw_pkg::CNT_W-1:0]    out_rem_ff;

   logic                         in_range_in;
   logic [fnw_pkg::CNT_W-1:0]    resident_in;
   logic [7:0]                   res8, ones8, inv8, fin8, d_plain, d_inv;
   logic [7:0]                   shift_inc, detect_inc, inj8, rem8;
   logic                         flip_in;
   logic [fnw_pkg::DATA_W-1:0]   stored_in;
   logic [fnw_pkg::TOTAL_W-1:0]  shift_total_in, detect_total_in;
   logic [fnw_pkg::TOTAL_W-1:0]  inject_total_in, remove_total_in;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = fnw_pkg::WIDTH_W'(1);
      end else if (width_ff > fnw_pkg::WIDTH_W'(fnw_pkg::DATA_W)) begin
         w_eff = fnw_pkg::WIDTH_W'(fnw_pkg::DATA_W);
      end else begin
         w_eff = width_ff;
      end
      if (w_eff == fnw_pkg::WIDTH_W'(fnw_pkg::DATA_W)) begin
         mask_in = '1;
      end else begin
         mask_in = (fnw_pkg::DATA_W'(1) << w_eff) - fnw_pkg::DATA_W'(1);
      end
   end

   assign in_range_in = (32'(entry_index) < 32'(fnw_pkg::NUM_ENTRIES));
   assign resident_in = ones_of(rd_ff[fnw_pkg::DATA_W-1:0] & mask_ff)
                        + fnw_pkg::CNT_W'(rd_ff[fnw_pkg::DATA_W]);

   // flip decision; ties keep the plain word
   always_comb begin
      res8    = 8'(resident_ff);
      ones8   = 8'(ones_ff);
      inv8    = 8'(w_ff) - ones8 + 8'd1;
      d_plain = (res8 >= ones8) ? (res8 - ones8) : (ones8 - res8);
      d_inv   = (res8 >= inv8)  ? (res8 - inv8)  : (inv8 - res8);
      flip_in = (d_inv < d_plain);
      fin8    = flip_in ? inv8 : ones8;
      stored_in = flip_in ? (~data_ff & mask_ff) : data_ff;
      inj8    = (fin8 > res8) ? (fin8 - res8) : 8'd0;
      rem8    = (res8 > fin8) ? (res8 - fin8) : 8'd0;
      shift_inc  = (8'(w_ff) << 1) + 8'd3;
      detect_inc = 8'(w_ff) + 8'd1;
      shift_total_in  = sat_add(shift_total_ff, shift_inc);
      detect_total_in = sat_add(detect_total_ff, detect_inc);
      inject_total_in = sat_add(inject_total_ff, inj8);
      remove_total_in = sat_add(remove_total_ff, rem8);
   end

   // table access
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clear_addr_ff] <= '0;
      end else if (cmd.commit && in_range_ff) begin
         mem[addr_ff] <= {flip_in, stored_in};
      end
      if (cmd.accept) begin
         rd_ff <= mem[fnw_pkg::ENTRY_AW'(entry_index)];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= fnw_pkg::WIDTH_RESET;
         clear_addr_ff   <= '0;
         shift_total_ff  <= '0;
         detect_total_ff <= '0;
         inject_total_ff <= '0;
         remove_total_ff <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            width_ff <= csr_data;
         end
         if (cmd.clear) begin
            clear_addr_ff <= clear_addr_ff + fnw_pkg::ENTRY_AW'(1);
         end
         if (cmd.commit) begin
            shift_total_ff  <= shift_total_in;
            detect_total_ff <= detect_total_in;
            inject_total_ff <= inject_total_in;
            remove_total_ff <= remove_total_in;
            out_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff    <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         addr_ff     <= fnw_pkg::ENTRY_AW'(entry_index);
         in_range_ff <= in_range_in;
         w_ff        <= w_eff;
         mask_ff     <= mask_in;
         data_ff     <= write_data & mask_in;
      end
      if (cmd.count) begin
         // out-of-range entries read as empty
         resident_ff <= in_range_ff ? resident_in : '0;
         ones_ff     <= ones_of(data_ff);
      end
      if (cmd.commit) begin
         out_flip_ff <= flip_in;
         out_word_ff <= stored_in;
         out_inj_ff  <= fnw_pkg::CNT_W'(inj8);
         out_rem_ff  <= fnw_pkg::CNT_W'(rem8);
      end
   end

   assign status.out_busy   = out_valid_ff && !rsp_tready;
   assign status.clear_last = (clear_addr_ff == fnw_pkg::ENTRY_AW'(fnw_pkg::NUM_ENTRIES - 1));

   assign rsp_tvalid       = out_valid_ff;
   assign flip_chosen      = out_flip_ff;
   assign stored_word      = out_word_ff;
   assign injected_now     = out_inj_ff;
   assign removed_now      = out_rem_ff;
   assign total_shifts     = shift_total_ff;
   assign total_detects    = detect_total_ff;
   assign total_injections = inject_total_ff;
   assign total_removals   = remove_total_ff;

endmodule

### design/flip_n_write_cost_model.sv
// ----------------------------------------------------------------------------
// flip_n_write_cost_model
// Flip-n-write cost model over a 1024-entry word table.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 1024 entries of the table to zero, one
// entry a cycle; req_tready stays low during the sweep, while data_width
// writes on the csr channel are taken at any time out of reset. Each write
// item then passes through table read, ones count of old and new word, and
// the commit step that decides the flip, writes the entry back and updates
// the saturating totals. The next item is taken right after commit; a result
// not yet taken holds the commit of the following item back.
module flip_n_write_cost_model (
   input  logic                             clock,
   input  logic                             reset,
   // csr write: data_width[6:0]
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fnw_pkg::WIDTH_W-1:0]      csr_data,
   // req_tdata: entry_index[9:0], write_data[73:10], zero pad [79:74]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fnw_pkg::REQ_W-1:0]        req_tdata,
   // rsp_tdata: stored_word[63:0], injected_now[70:64], removed_now[77:71],
   // total_shifts[141:78], total_detects[205:142], total_injections[269:206],
   // total_removals[333:270], zero pad [335:334]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fnw_pkg::RSP_W-1:0]        rsp_tdata,
   // rsp_tuser: flip_chosen[0]
   output logic                             rsp_tuser
);

   fnw_pkg::cmd_type    cmd;
   fnw_pkg::status_type status;

   logic [fnw_pkg::CNT_W-1:0]   injected_now;
   logic [fnw_pkg::CNT_W-1:0]   removed_now;
   logic [fnw_pkg::DATA_W-1:0]  stored_word;
   logic [fnw_pkg::TOTAL_W-1:0] total_shifts;
   logic [fnw_pkg::TOTAL_W-1:0] total_detects;
   logic [fnw_pkg::TOTAL_W-1:0] total_injections;
   logic [fnw_pkg::TOTAL_W-1:0] total_removals;

   // the width register ignores writes while reset is high
   assign csr_ready = !reset;

   fnw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fnw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .entry_index      (req_tdata[9:0]),
      .write_data       (req_tdata[73:10]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .flip_chosen      (rsp_tuser),
      .stored_word      (stored_word),
      .injected_now     (injected_now),
      .removed_now      (removed_now),
      .total_shifts     (total_shifts),
      .total_detects    (total_detects),
      .total_injections (total_injections),
      .total_removals   (total_removals)
   );

   assign rsp_tdata = {2'b00, total_removals, total_injections, total_detects,
                       total_shifts, removed_now, injected_now, stored_word};

endmodule

### design/fnw_checker.sv
// ----------------------------------------------------------------------------
// fnw_checker
// Port-level checks for the flip-n-write cost model.
// ----------------------------------------------------------------------------
module fnw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [fnw_pkg::RSP_W-1:0]  rsp_tdata,
   input logic                       rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // a write never both injects and removes
   a_inj_xor_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[70:64] == 7'd0) || (rsp_tdata[77:71] == 7'd0))
      else $error("injected and removed both nonzero");

   // every write adds at least five shifts
   a_shifts_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[141:78] != 64'd0)
      else $error("total_shifts zero with a result pending");

   // a result does not rise in the cycle after its item is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared one cycle after request");

endmodule

bind flip_n_write_cost_model fnw_checker u_fnw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_flip_n_write_cost_model.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flip_n_write_cost_model
// Self-checking bench for the flip-n-write cost model. A queue of write
// items feeds a clocked stream driver. The monitor keeps its own copy of the
// entry table, the flip bits and the saturating totals, predicts each result
// when a write is taken, and compares every returned result field by field.
// data_width is changed between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module tb_flip_n_write_cost_model;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 10;    // read, count and commit steps plus margin
   localparam int PHASE_ITEMS = 84;

   typedef struct packed {
      logic [fnw_pkg::IDX_W-1:0]  entry;
      logic [fnw_pkg::DATA_W-1:0] data;
   } write_item_type;

   typedef struct packed {
      logic                        flip;
      logic [fnw_pkg::DATA_W-1:0]  word;
      logic [fnw_pkg::CNT_W-1:0]   injected;
      logic [fnw_pkg::CNT_W-1:0]   removed;
      logic [fnw_pkg::TOTAL_W-1:0] shifts;
      logic [fnw_pkg::TOTAL_W-1:0] detects;
      logic [fnw_pkg::TOTAL_W-1:0] injections;
      logic [fnw_pkg::TOTAL_W-1:0] removals;
   } write_result_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [fnw_pkg::WIDTH_W-1:0]   csr_data   = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [fnw_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [fnw_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          rsp_tuser;

   // predicted state of the block
   logic [fnw_pkg::DATA_W-1:0]    word_table [fnw_pkg::NUM_ENTRIES];
   logic                          flip_table [fnw_pkg::NUM_ENTRIES];
   logic [fnw_pkg::TOTAL_W-1:0]   shift_sum  = '0;
   logic [fnw_pkg::TOTAL_W-1:0]   detect_sum = '0;
   logic [fnw_pkg::TOTAL_W-1:0]   inject_sum = '0;
   logic [fnw_pkg::TOTAL_W-1:0]   remove_sum = '0;
   logic [fnw_pkg::WIDTH_W-1:0]   width_reg  = fnw_pkg::WIDTH_RESET;

   write_item_type       write_queue[$];
   write_result_type     result_queue[$];
   int unsigned          errors       = 0;
   int unsigned          results_seen = 0;
   int unsigned          flips_seen   = 0;
   int unsigned          width_writes = 0;
   int unsigned          cycle_count;
   int unsigned          req_gap      = 0;
   int unsigned          rsp_stall    = 0;
   bit                   idle_on      = 1'b1;

   flip_n_write_cost_model DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < fnw_pkg::NUM_ENTRIES; i++) begin
         word_table[i] = '0;
         flip_table[i] = 1'b0;
      end
   end

   function automatic logic [fnw_pkg::TOTAL_W-1:0] sat_add(
      logic [fnw_pkg::TOTAL_W-1:0] a,
      logic [fnw_pkg::TOTAL_W-1:0] b);
      logic [fnw_pkg::TOTAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[fnw_pkg::TOTAL_W] ? '1 : s[fnw_pkg::TOTAL_W-1:0];
   endfunction

   // one table write: choose plain or inverted, update entry and totals
   function automatic write_result_type apply_write(logic [fnw_pkg::IDX_W-1:0] entry,
                                                    logic [fnw_pkg::DATA_W-1:0] data);
      int unsigned                w;
      int unsigned                resident;
      int unsigned                ones;
      int unsigned                inv_ones;
      int unsigned                d_plain;
      int unsigned                d_inv;
      logic [fnw_pkg::DATA_W-1:0] mask;
      logic [fnw_pkg::DATA_W-1:0] word;
      write_result_type           r;
      if (width_reg == '0)
         w = 1;
      else if (int'(width_reg) > fnw_pkg::DATA_W)
         w = fnw_pkg::DATA_W;
      else
         w = int'(width_reg);
      mask = (w == fnw_pkg::DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
      resident = $countones(word_table[entry] & mask) + int'(flip_table[entry]);
      word = data & mask;
      ones = $countones(word);
      inv_ones = w - ones + 1;
      d_plain = (resident > ones) ? resident - ones : ones - resident;
      d_inv = (resident > inv_ones) ? resident - inv_ones : inv_ones - resident;
      r.flip = (d_inv < d_plain);
      if (r.flip) begin
         word = ~word & mask;
         ones = inv_ones;
      end
      r.word = word;
      r.injected = (ones > resident) ? fnw_pkg::CNT_W'(ones - resident) : '0;
      r.removed = (resident > ones) ? fnw_pkg::CNT_W'(resident - ones) : '0;
      shift_sum = sat_add(shift_sum, fnw_pkg::TOTAL_W'(2 * w + 3));
      detect_sum = sat_add(detect_sum, fnw_pkg::TOTAL_W'(w + 1));
      inject_sum = sat_add(inject_sum, fnw_pkg::TOTAL_W'(r.injected));
      remove_sum = sat_add(remove_sum, fnw_pkg::TOTAL_W'(r.removed));
      word_table[entry] = word;
      flip_table[entry] = r.flip;
      r.shifts = shift_sum;
      r.detects = detect_sum;
      r.injections = inject_sum;
      r.removals = remove_sum;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // write driver
   always @(posedge clock) begin : write_driver
      write_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (write_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else begin
            item = write_queue.pop_front();
            req_tdata <= {6'b0, item.data, item.entry};
            req_tvalid <= 1'b1;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // predict on each taken write, compare each taken result
   always @(posedge clock) begin : result_monitor
      write_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            width_reg = csr_data;
         if (req_tvalid && req_tready)
            result_queue.push_back(apply_write(req_tdata[9:0], req_tdata[73:10]));
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser)
               flips_seen++;
            if (result_queue.size() == 0) begin
               $error("result item with no write outstanding");
               errors++;
            end else begin
               want = result_queue.pop_front();
               check_field("flip_chosen", 64'(want.flip), 64'(rsp_tuser));
               check_field("stored_word", want.word, rsp_tdata[63:0]);
               check_field("injected_now", 64'(want.injected), 64'(rsp_tdata[70:64]));
               check_field("removed_now", 64'(want.removed), 64'(rsp_tdata[77:71]));
               check_field("total_shifts", want.shifts, rsp_tdata[141:78]);
               check_field("total_detects", want.detects, rsp_tdata[205:142]);
               check_field("total_injections", want.injections, rsp_tdata[269:206]);
               check_field("total_removals", want.removals, rsp_tdata[333:270]);
               check_field("pad", '0, 64'(rsp_tdata[335:334]));
            end
         end
      end
   end

   task automatic queue_write(int unsigned entry, logic [fnw_pkg::DATA_W-1:0] data);
      write_item_type item;
      item.entry = fnw_pkg::IDX_W'(entry);
      item.data = data;
      write_queue.push_back(item);
   endtask

   // sample at the falling edge so the driver's updates have settled
   task automatic drain();
      while (write_queue.size() != 0 || req_tvalid || result_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_width(int unsigned value);
      csr_valid <= 1'b1;
      csr_data <= fnw_pkg::WIDTH_W'(value);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      width_writes++;
   endtask

   function automatic logic [fnw_pkg::DATA_W-1:0] random_word();
      logic [fnw_pkg::DATA_W-1:0] v;
      case ($urandom_range(0, 5))
         0: begin
            v = '0;
            repeat ($urandom_range(1, 3)) v[$urandom_range(0, 63)] = 1'b1;
         end
         1: begin
            v = '1;
            repeat ($urandom_range(1, 3)) v[$urandom_range(0, 63)] = 1'b0;
         end
         2: v = $urandom_range(0, 1) ? '0 : '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   function automatic int unsigned random_entry();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      // mostly a few hot entries so that old contents matter
      if (pick < 7)
         return $urandom_range(0, 15);
      else if (pick < 9)
         return $urandom_range(0, fnw_pkg::NUM_ENTRIES - 1);
      else
         return $urandom_range(0, 1) ? fnw_pkg::NUM_ENTRIES - 1 : 0;
   endfunction

   initial begin
      int unsigned phase_width [9];
      int unsigned w;
      phase_width = '{1, 64, 33, 2, 0, 65, 63, 0, 64};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset width of 64: extremes, repeated all-ones, alternating patterns
      queue_write(0, '0);
      queue_write(0, '1);
      queue_write(0, '1);
      queue_write(fnw_pkg::NUM_ENTRIES - 1, '1);
      queue_write(fnw_pkg::NUM_ENTRIES - 1, 64'h5555_5555_5555_5555);
      queue_write(3, 64'hFFFF_0000_FFFF_0000);
      queue_write(3, 64'h8000_0000_0000_0001);
      queue_write(9, 64'hAAAA_AAAA_AAAA_AAAA);
      drain();

      // odd width: tie on a fresh entry, old word counted only in low bits
      set_width(7);
      queue_write(2, 64'h0F);
      queue_write(3, 64'hFFFF_FFFF_FFFF_FF80);
      queue_write(4, 64'h7F);
      queue_write(4, 64'h7F);
      queue_write(2, 64'hFFFF_FFFF_FFFF_FF8F);
      drain();

      // zero width acts as one bit
      set_width(0);
      queue_write(5, 64'h1);
      queue_write(5, '1);
      queue_write(5, '0);
      drain();

      // all-ones register value acts as 64
      set_width(127);
      queue_write(6, '1);
      queue_write(2, '1);
      queue_write(fnw_pkg::NUM_ENTRIES - 1, '0);
      drain();

      for (int p = 0; p < 9; p++) begin
         w = phase_width[p];
         if (p == 4)
            w = $urandom_range(3, 62);
         else if (p == 7)
            w = $urandom_range(0, 127);
         set_width(w);
         if (p == 8)
            idle_on <= 1'b0;
         repeat (PHASE_ITEMS) queue_write(random_entry(), random_word());
         drain();
      end

      $display("Covered %0d writes (%0d stored inverted) over %0d data_width settings,",
               results_seen, flips_seen, width_writes);
      $display("including widths 0, 1, 2, 7, 33, 63, 64, 65 and 127, with random idling.");
      if (errors == 0 && result_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("Timed out after %0d cycles", CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
